// ===== src/msd_pkg.sv =====
// Package for the Morse stream decoder: field widths, character codes,
// the token that travels down the lookup chain and the byte mask function.
// No dependencies.
package msd_pkg;

  localparam int CHAR_W = 8;
  localparam int CODE_BYTES = 8;
  localparam int CODE_W = CHAR_W * CODE_BYTES;
  localparam int LEN_W = 4;
  localparam int RUN_W = 3;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;
  localparam logic [CHAR_W-1:0] FAIL_CHAR = 8'd42;
  localparam logic [RUN_W-1:0] GAP_LIMIT = 3'd3;
  localparam logic [RUN_W-1:0] RUN_SAT = 3'd4;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STREAM = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [CODE_W-1:0] key;
    logic [LEN_W-1:0]  klen;
    logic [CHAR_W-1:0] sym;
  } msd_tok_t;

  function automatic logic [CODE_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
    logic [CODE_W-1:0] m;
    m = '0;
    for (int b = 0; b < CODE_BYTES; b++) begin
      if (LEN_W'(b) < n) begin
        m[b*CHAR_W +: CHAR_W] = '1;
      end
    end
    return m;
  endfunction

endpackage

// ===== src/morse_stream_decoder_top.sv =====
// Top level of the Morse stream decoder: stream front end, code buffer,
// table load control, the chain of lookup cells and the output register.
// Depends on msd_pkg and msd_cell.
//
// Load words and stream words are taken whenever input is not held off. A
// space that ends a code starts a lookup that walks the chain of
// TABLE_ENTRIES cells, one cell per cycle; input is held off until the token
// leaves the last cell and the result is loaded into the output register. A
// buffer overflow gives its result without a lookup. The lowest loaded entry
// that matches wins. A result waits in an output register, and outside a
// lookup input is held off only while that register is stalled.
module morse_stream_decoder_top #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MAX_CODE_LEN = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [msd_pkg::CHAR_W-1:0]     in_char,
  input  logic [msd_pkg::CHAR_W-1:0]     in_entry_symbol,
  input  logic [msd_pkg::CODE_W-1:0]     in_entry_code,
  input  logic [msd_pkg::LEN_W-1:0]      in_entry_code_len,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [msd_pkg::CHAR_W-1:0]     out_char,
  output logic                           out_not_found,
  output logic                           out_code_overflow
);
  import msd_pkg::*;

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic {ST_IDLE, ST_SEARCH} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CODE_W-1:0] buf_r, buf_nxt;
  logic [LEN_W-1:0]  blen_r, blen_nxt;
  logic              ovf_r, ovf_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_nf_r, out_nf_nxt;
  logic              out_ov_r, out_ov_nxt;

  logic              accept;
  logic              load_go;
  logic [CODE_W-1:0] ld_code;
  msd_tok_t          tok0;
  msd_tok_t          chain [TABLE_ENTRIES+1];
  logic              live [TABLE_ENTRIES];
  logic              ld_en [TABLE_ENTRIES];

  assign in_stall = (state_r == ST_SEARCH) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign load_go  = accept && (in_action == ACT_LOAD) && (cnt_r < CNT_W'(TABLE_ENTRIES));
  assign ld_code  = in_entry_code & byte_mask(in_entry_code_len);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    buf_nxt       = buf_r;
    blen_nxt      = blen_r;
    ovf_nxt       = ovf_r;
    run_nxt       = run_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_nf_nxt    = out_nf_r;
    out_ov_nxt    = out_ov_r;
    tok0          = '0;
    tok0.key      = buf_r;
    tok0.klen     = blen_r;
    tok0.sym      = FAIL_CHAR;

    if (load_go) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    if (accept && (in_action == ACT_STREAM)) begin
      if (in_char != SPACE_CHAR) begin
        if (run_r > GAP_LIMIT) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = SPACE_CHAR;
          out_nf_nxt    = 1'b0;
          out_ov_nxt    = 1'b0;
        end
        run_nxt = '0;
        if (blen_r < LEN_W'(MAX_CODE_LEN)) begin
          buf_nxt[{blen_r[2:0], 3'b000} +: CHAR_W] = in_char;
          blen_nxt = blen_r + LEN_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end else if (run_r == '0) begin
        if (ovf_r) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = FAIL_CHAR;
          out_nf_nxt    = 1'b0;
          out_ov_nxt    = 1'b1;
        end else begin
          tok0.valid = 1'b1;
          state_nxt  = ST_SEARCH;
        end
        buf_nxt  = '0;
        blen_nxt = '0;
        ovf_nxt  = 1'b0;
        run_nxt  = RUN_W'(1);
      end else if (run_r < RUN_SAT) begin
        run_nxt = run_r + RUN_W'(1);
      end
    end

    if (chain[TABLE_ENTRIES].valid) begin
      state_nxt     = ST_IDLE;
      out_valid_nxt = 1'b1;
      out_char_nxt  = chain[TABLE_ENTRIES].hit ? chain[TABLE_ENTRIES].sym : FAIL_CHAR;
      out_nf_nxt    = !chain[TABLE_ENTRIES].hit;
      out_ov_nxt    = 1'b0;
    end
  end

  assign chain[0] = tok0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    assign live[g]  = cnt_r > CNT_W'(g);
    assign ld_en[g] = load_go && (cnt_r == CNT_W'(g));

    msd_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ld_en   (ld_en[g]),
      .ld_sym  (in_entry_symbol),
      .ld_code (ld_code),
      .ld_len  (in_entry_code_len),
      .live    (live[g]),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_nf_r   <= out_nf_nxt;
    out_ov_r   <= out_ov_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      buf_r       <= '0;
      blen_r      <= '0;
      ovf_r       <= 1'b0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      buf_r       <= buf_nxt;
      blen_r      <= blen_nxt;
      ovf_r       <= ovf_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_char          = out_char_r;
  assign out_not_found     = out_nf_r;
  assign out_code_overflow = out_ov_r;

endmodule

// ===== src/msd_cell.sv =====
// One cell of the lookup chain: holds a single table entry and passes the
// search token to its neighbour every cycle, marking the first match.
// Depends on msd_pkg.
module msd_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           ld_en,
  input  logic [msd_pkg::CHAR_W-1:0]     ld_sym,
  input  logic [msd_pkg::CODE_W-1:0]     ld_code,
  input  logic [msd_pkg::LEN_W-1:0]      ld_len,
  input  logic                           live,
  input  msd_pkg::msd_tok_t              tok_in,
  output msd_pkg::msd_tok_t              tok_out
);
  import msd_pkg::*;

  logic [CHAR_W-1:0] sym_r;
  logic [CODE_W-1:0] code_r;
  logic [LEN_W-1:0]  len_r;
  msd_tok_t          tok_r;
  msd_tok_t          tok_nxt;
  logic              match;

  assign match = live && !tok_in.hit && (len_r == tok_in.klen) && (code_r == tok_in.key);

  always_comb begin
    tok_nxt = tok_in;
    if (match) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.sym = sym_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_en) begin
      sym_r  <= ld_sym;
      code_r <= ld_code;
      len_r  <= ld_len;
    end
    tok_r.hit  <= tok_nxt.hit;
    tok_r.key  <= tok_nxt.key;
    tok_r.klen <= tok_nxt.klen;
    tok_r.sym  <= tok_nxt.sym;
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== tb/morse_stream_decoder_top_test.sv =====
// Self-checking testbench for morse_stream_decoder_top: directed and random table loads
// and text streams, with a built-in decoder model that predicts every output word.
// Depends on msd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module morse_stream_decoder_top_test;
  import msd_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int MAX_CODE = 8;
  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 7;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 20;
  localparam int WATCHDOG_CYCLES = 1_500_000;

  typedef struct packed {
    logic              action;
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } decoder_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              not_found;
    logic              overflow;
  } decoded_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_action;
  logic [CHAR_W-1:0] in_char;
  logic [CHAR_W-1:0] in_entry_symbol;
  logic [CODE_W-1:0] in_entry_code;
  logic [LEN_W-1:0]  in_entry_code_len;
  logic              out_valid;
  logic              out_stall;
  logic [CHAR_W-1:0] out_char;
  logic              out_not_found;
  logic              out_code_overflow;

  // Decoder model state.
  logic [CHAR_W-1:0] tbl_sym [TABLE_DEPTH];
  logic [CODE_W-1:0] tbl_code [TABLE_DEPTH];
  logic [LEN_W-1:0]  tbl_len [TABLE_DEPTH];
  int                table_fill = 0;
  logic [CODE_W-1:0] code_acc = '0;
  int                code_len = 0;
  bit                code_ovf = 1'b0;
  int                spaces = 0;

  decoded_t pending_symbols[$];
  int       usable_entries[$];
  int       mismatches = 0;
  int       items_sent = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  bit       hold_armed = 1'b0;

  morse_stream_decoder_top #(
    .TABLE_ENTRIES(TABLE_DEPTH),
    .MAX_CODE_LEN(MAX_CODE)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_char(in_char),
    .in_entry_symbol(in_entry_symbol),
    .in_entry_code(in_entry_code),
    .in_entry_code_len(in_entry_code_len),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char(out_char),
    .out_not_found(out_not_found),
    .out_code_overflow(out_code_overflow)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [CODE_W-1:0] low_bytes(input int n);
    if (n >= CODE_BYTES) begin
      return '1;
    end
    return (CODE_W'(1) << (CHAR_W * n)) - CODE_W'(1);
  endfunction

  function automatic void decode_word(input decoder_word_t w);
    decoded_t res;
    bit found;
    if (w.action == ACT_LOAD) begin
      if (table_fill < TABLE_DEPTH) begin
        tbl_sym[table_fill] = w.sym;
        tbl_code[table_fill] = w.code & low_bytes(w.len);
        tbl_len[table_fill] = w.len;
        table_fill++;
      end
    end else if (w.ch != SPACE_CHAR) begin
      if (spaces > GAP_LIMIT) begin
        res = '{SPACE_CHAR, 1'b0, 1'b0};
        pending_symbols = {pending_symbols, res};
      end
      spaces = 0;
      if (code_len < MAX_CODE) begin
        code_acc[CHAR_W*code_len +: CHAR_W] = w.ch;
        code_len++;
      end else begin
        code_ovf = 1'b1;
      end
    end else if (spaces == 0) begin
      if (code_ovf) begin
        res = '{FAIL_CHAR, 1'b0, 1'b1};
      end else begin
        found = 1'b0;
        res = '{FAIL_CHAR, 1'b1, 1'b0};
        for (int i = 0; i < table_fill; i++) begin
          if (!found && tbl_len[i] == code_len &&
              tbl_code[i] == (code_acc & low_bytes(code_len))) begin
            found = 1'b1;
            res = '{tbl_sym[i], 1'b0, 1'b0};
          end
        end
      end
      pending_symbols = {pending_symbols, res};
      code_acc = '0;
      code_len = 0;
      code_ovf = 1'b0;
      spaces = 1;
    end else if (spaces < RUN_SAT) begin
      spaces++;
    end
  endfunction

  task automatic send_word(input decoder_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= w.action;
    in_char <= w.ch;
    in_entry_symbol <= w.sym;
    in_entry_code <= w.code;
    in_entry_code_len <= w.len;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    if (!(w.action == ACT_LOAD && table_fill >= TABLE_DEPTH)) begin
      items_sent++;
    end
    decode_word(w);
  endtask

  task automatic stream_byte(input logic [CHAR_W-1:0] ch);
    decoder_word_t w;
    w.action = ACT_STREAM;
    w.ch = ch;
    w.sym = CHAR_W'($urandom);
    w.code = {$urandom, $urandom};
    w.len = LEN_W'($urandom);
    send_word(w);
  endtask

  task automatic load_entry(input logic [CHAR_W-1:0] sym, input logic [CODE_W-1:0] code,
                            input logic [LEN_W-1:0] len);
    decoder_word_t w;
    w.action = ACT_LOAD;
    w.ch = CHAR_W'($urandom);
    w.sym = sym;
    w.code = code;
    w.len = len;
    send_word(w);
  endtask

  function automatic logic [CHAR_W-1:0] code_char(input bit morse);
    logic [CHAR_W-1:0] b;
    if (morse) begin
      return $urandom_range(1) ? CHAR_W'(".") : CHAR_W'("-");
    end
    do begin
      b = CHAR_W'($urandom_range(255));
    end while (b == SPACE_CHAR);
    return b;
  endfunction

  task automatic load_random_entry();
    logic [CODE_W-1:0] code;
    int len;
    bit morse;
    code = {$urandom, $urandom};
    morse = $urandom_range(1);
    case ($urandom_range(7))
      0: len = $urandom_range(9, 15);
      1, 2: len = $urandom_range(0, MAX_CODE);
      default: len = $urandom_range(1, 4);
    endcase
    for (int i = 0; i < CODE_BYTES && i < len; i++) begin
      code[CHAR_W*i +: CHAR_W] = code_char(morse);
    end
    load_entry(CHAR_W'($urandom), code, LEN_W'(len));
  endtask

  task automatic send_sequence(input bit noisy);
    int idx;
    int n;
    int gap;
    if (!noisy) begin
      idx = usable_entries[$urandom_range(usable_entries.size() - 1)];
      for (int i = 0; i < tbl_len[idx]; i++) begin
        stream_byte(tbl_code[idx][CHAR_W*i +: CHAR_W]);
      end
    end else begin
      n = $urandom_range(1, MAX_CODE + 2);
      case ($urandom_range(2))
        0: repeat (n) stream_byte(CHAR_W'($urandom_range(255)));
        1: load_random_entry();
        default: repeat (n) stream_byte(code_char(1'b1));
      endcase
    end
    gap = ($urandom_range(3) == 0) ? $urandom_range(2, 6) : 1;
    repeat (gap) stream_byte(SPACE_CHAR);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_symbols.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    int target;
    idle_pct = idle;
    stall_pct = stall;
    target = items_sent + count;
    while (items_sent < target) begin
      send_sequence($urandom_range(3) == 0);
    end
  endtask

  // A lookup of the empty buffer at stream start, then spaces that only count.
  task automatic test_empty_table();
    repeat (4) stream_byte(SPACE_CHAR);
  endtask

  task automatic test_directed_entries();
    load_entry("E", 64'h5A5A_5A5A_5A5A_5A2E, 4'd1);
    load_entry("A", 64'hC3C3_C3C3_C3C3_2D2E, 4'd2);
    load_entry("X", 64'h0000_0000_0000_2D2E, 4'd2);
    load_entry(8'h00, '0, 4'd8);
    load_entry(8'hFF, '1, 4'd8);
    load_entry("#", 64'h1234, 4'd0);
    load_entry("L", '1, 4'd15);
  endtask

  // The first byte here follows a saturated run of spaces, so a word gap comes first.
  task automatic test_directed_decode();
    stream_byte(".");
    stream_byte(SPACE_CHAR);
    stream_byte(".");
    stream_byte("-");
    stream_byte(SPACE_CHAR);
    for (int i = 0; i <= MAX_CODE; i++) begin
      stream_byte((i % 2 == 0) ? CHAR_W'("-") : CHAR_W'("."));
    end
    stream_byte(SPACE_CHAR);
  endtask

  task automatic test_table_full();
    bit has_space;
    while (table_fill < TABLE_DEPTH) begin
      load_random_entry();
    end
    repeat (4) load_random_entry();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      has_space = 1'b0;
      for (int b = 0; b < tbl_len[i] && b < CODE_BYTES; b++) begin
        if (tbl_code[i][CHAR_W*b +: CHAR_W] == SPACE_CHAR) begin
          has_space = 1'b1;
        end
      end
      if (tbl_len[i] <= MAX_CODE && !has_space) begin
        usable_entries = {usable_entries, i};
      end
    end
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0, 380);
    run_phase(54, 0, 380);
    run_phase(0, 54, 380);
    run_phase(23, 23, 380);
  endtask

  task automatic test_back_pressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_armed = 1'b1;
    repeat (30) send_sequence(1'b0);
  endtask

  task automatic test_drain_pause();
    idle_pct = 10;
    stall_pct = 10;
    repeat (10) send_sequence(1'b0);
    pause_until_drained();
    repeat (10) send_sequence($urandom_range(3) == 0);
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_symbols.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output word, expected none, got char %0d nf %0b ov %0b",
                 $time, out_char, out_not_found, out_code_overflow);
      end else begin
        want = pending_symbols.pop_front();
        if (out_char !== want.ch || out_not_found !== want.not_found ||
            out_code_overflow !== want.overflow) begin
          mismatches++;
          $display("%0t: mismatch, expected %0d nf %0b ov %0b, got %0d nf %0b ov %0b",
                   $time, want.ch, want.not_found, want.overflow,
                   out_char, out_not_found, out_code_overflow);
        end
      end
    end
  end

  initial begin
    #(WATCHDOG_CYCLES * CLK_PERIOD);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_STREAM;
    in_char = '0;
    in_entry_symbol = '0;
    in_entry_code = '0;
    in_entry_code_len = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_directed_entries();
    test_directed_decode();
    test_table_full();
    test_random_traffic();
    test_back_pressure();
    test_drain_pause();

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/msd_pkg.sv
src/msd_cell.sv
src/morse_stream_decoder_top.sv
tb/morse_stream_decoder_top_test.sv
